### hw/rtl/integer_to_radix_ascii_macros.svh
// -----------------------------------------------------------------------------
// integer_to_radix_ascii assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk and held off in reset.
// -----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_MACROS_SVH

`ifndef ASSERT_OFF
// plain property check
`define IRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// same-cycle implication
`define IRA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define IRA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IRA_ASSERT(lbl, prop, msg)
`define IRA_ASSERT_IMP(lbl, ante, cons, msg)
`define IRA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/ira_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ira_pkg
// Types, constants and the digit-to-character map of the radix text converter.
// -----------------------------------------------------------------------------
package ira_pkg;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 8;

    typedef logic [RADIX_W-1:0] t_radix;
    typedef logic [RADIX_W-1:0] t_digit;
    typedef logic [CHAR_W-1:0]  t_char;

    localparam t_radix RADIX_MIN    = 6'd2;
    localparam t_radix RADIX_MAX    = 6'd36;
    localparam t_radix RADIX_RESET  = 6'd10;
    localparam t_radix SIGNED_RADIX = 6'd10;

    localparam t_char CHAR_ZERO  = 8'h30;
    localparam t_char CHAR_A     = 8'h61;
    localparam t_char CHAR_MINUS = 8'h2d;
    localparam t_char CHAR_NONE  = 8'h00;

    // start clears the digit cells and loads the magnitude, shift moves digits up
    typedef struct packed {
        logic start;
        logic shift;
    } t_conv_ctrl;

    function automatic t_char digit_char(input t_digit d);
        if (d < 6'd10) begin
            return CHAR_ZERO + {2'b00, d};
        end else begin
            return CHAR_A + {2'b00, d} - 8'd10;
        end
    endfunction

endpackage

### hw/rtl/ira_digit_cell.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ira_digit_cell
// One radix digit: doubles and adds the incoming carry, folding back into range.
// -----------------------------------------------------------------------------
module ira_digit_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ira_pkg::t_conv_ctrl i_ctrl,
    input  logic               i_en,
    input  logic               i_cin,
    input  ira_pkg::t_radix    i_radix,
    input  ira_pkg::t_digit    i_shift_in,
    output ira_pkg::t_digit    o_digit,
    output logic               o_cout,
    output logic               o_en
);
    import ira_pkg::*;

    t_digit     r_digit, n_digit;
    logic       r_cout, n_cout;
    logic       r_en;
    logic [6:0] w_sum;
    logic [6:0] w_diff;
    logic       w_ge;

    // digit < radix so 2*digit+1 < 2*radix: one subtract is enough
    assign w_sum  = {r_digit, i_cin};
    assign w_ge   = w_sum >= {1'b0, i_radix};
    assign w_diff = w_sum - {1'b0, i_radix};

    always_comb begin
        n_digit = r_digit;
        n_cout  = r_cout;
        if (i_ctrl.start) begin
            n_digit = '0;
            n_cout  = 1'b0;
        end else if (i_ctrl.shift) begin
            n_digit = i_shift_in;
        end else if (i_en) begin
            n_digit = w_ge ? w_diff[RADIX_W-1:0] : w_sum[RADIX_W-1:0];
            n_cout  = w_ge;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
        r_cout  <= n_cout;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
        end else begin
            r_en <= i_en && !i_ctrl.start;
        end
    end

    assign o_digit = r_digit;
    assign o_cout  = r_cout;
    assign o_en    = r_en;

endmodule

### hw/rtl/ira_converter.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ira_converter
// Bit-serial binary to radix conversion through a skewed chain of digit cells.
// -----------------------------------------------------------------------------
module ira_converter #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ira_pkg::t_conv_ctrl   i_ctrl,
    input  logic [VALUE_BITS-1:0] i_mag,
    input  ira_pkg::t_radix       i_radix,
    output logic                  o_done,
    output ira_pkg::t_digit       o_top_digit
);
    import ira_pkg::*;

    localparam int NDIG  = VALUE_BITS;
    localparam int CNT_W = $clog2(VALUE_BITS + NDIG);
    localparam logic [CNT_W-1:0] FEED_END = CNT_W'(VALUE_BITS);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(VALUE_BITS + NDIG - 2);

    logic [VALUE_BITS-1:0] r_bits;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic                  w_feed;

    t_digit w_digit [NDIG];
    logic   w_cout  [NDIG];
    logic   w_en    [NDIG];

    assign w_feed = r_busy && (r_cnt < FEED_END);

    // magnitude leaves msb first, one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_bits <= i_mag;
        end else if (w_feed) begin
            r_bits <= {r_bits[VALUE_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_ctrl.start) begin
            r_cnt  <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            // last cell takes its final carry at this count
            if (r_cnt == LAST_CNT) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    for (genvar k = 0; k < NDIG; k++) begin : g_cell
        if (k == 0) begin : g_first
            ira_digit_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (i_ctrl),
                .i_en       (w_feed),
                .i_cin      (r_bits[VALUE_BITS-1]),
                .i_radix    (i_radix),
                .i_shift_in ('0),
                .o_digit    (w_digit[k]),
                .o_cout     (w_cout[k]),
                .o_en       (w_en[k])
            );
        end else begin : g_rest
            ira_digit_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (i_ctrl),
                .i_en       (w_en[k-1]),
                .i_cin      (w_cout[k-1]),
                .i_radix    (i_radix),
                .i_shift_in (w_digit[k-1]),
                .o_digit    (w_digit[k]),
                .o_cout     (w_cout[k]),
                .o_en       (w_en[k])
            );
        end
    end

    assign o_done      = r_done;
    assign o_top_digit = w_digit[NDIG-1];

endmodule

### hw/rtl/integer_to_radix_ascii.sv
`timescale 1ns / 1ps
// flow: the magnitude runs through the digit cell chain (carry steps, then done flag),
// then digits shift out (leading zeros dropped, characters sent), after a minus sign
// for a negative number in radix 10; an invalid radix sends one empty-text marker
// one item at a time: a new number is taken only when the block is back in idle
// reset: synchronous active-low i_rst_n, radix returns to 10, block idle and empty
// -----------------------------------------------------------------------------
// integer_to_radix_ascii
// Signed integer to lower-case text in radix 2 to 36, one character per item.
// -----------------------------------------------------------------------------
module integer_to_radix_ascii #(
    parameter int VALUE_BITS = 32,
    localparam int S_DATA_W  = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  ira_pkg::t_radix     i_cfg_wr_data,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // number_in, zero padded
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output ira_pkg::t_char      o_m_tdata,   // char_code
    output logic                o_m_tlast,   // last_char
    output logic                o_m_tuser    // empty_text
);
    import ira_pkg::*;

    localparam int NDIG   = VALUE_BITS;
    localparam int LEFT_W = $clog2(NDIG + 1);
    localparam logic [LEFT_W-1:0] LEFT_INIT = LEFT_W'(NDIG);
    localparam logic [LEFT_W-1:0] LEFT_ONE  = LEFT_W'(1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SIGN = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_BAD  = 3'd4;

    logic [2:0]        r_state, n_state;
    t_radix            r_radix;
    logic              r_neg, n_neg;
    logic [LEFT_W-1:0] r_left, n_left;
    logic              r_started, n_started;
    logic              r_m_valid, n_m_valid;
    t_char             r_m_data, n_m_data;
    logic              r_m_last, n_m_last;
    logic              r_m_empty, n_m_empty;

    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_s_acc;
    logic                  w_radix_ok;
    logic                  w_can_load;
    logic                  w_skip;
    logic                  w_emit;
    logic                  w_done;
    t_digit                w_top;
    t_conv_ctrl            w_ctrl;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_raw      = i_s_tdata[VALUE_BITS-1:0];
    // most negative value negates to itself, which is the right unsigned magnitude
    assign w_mag      = w_raw[VALUE_BITS-1] ? (~w_raw + VALUE_BITS'(1)) : w_raw;
    assign w_radix_ok = (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX);
    assign w_can_load = !r_m_valid || i_m_tready;

    // leading zeros are dropped, but the last digit always goes out
    assign w_skip = (r_state == ST_EMIT) && !r_started && (w_top == '0) && (r_left != LEFT_ONE);
    assign w_emit = (r_state == ST_EMIT) && !w_skip && w_can_load;

    assign w_ctrl.start = w_s_acc && w_radix_ok;
    assign w_ctrl.shift = w_skip || w_emit;

    ira_converter #(
        .VALUE_BITS (VALUE_BITS)
    ) u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_mag       (w_mag),
        .i_radix     (r_radix),
        .o_done      (w_done),
        .o_top_digit (w_top)
    );

    always_comb begin
        n_state   = r_state;
        n_neg     = r_neg;
        n_left    = r_left;
        n_started = r_started;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_data  = r_m_data;
        n_m_last  = r_m_last;
        n_m_empty = r_m_empty;
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    n_neg     = w_raw[VALUE_BITS-1];
                    n_left    = LEFT_INIT;
                    n_started = 1'b0;
                    n_state   = w_radix_ok ? ST_CONV : ST_BAD;
                end
            end
            ST_CONV: begin
                if (w_done) begin
                    n_state = (r_neg && (r_radix == SIGNED_RADIX)) ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (w_can_load) begin
                    n_m_valid = 1'b1;
                    n_m_data  = CHAR_MINUS;
                    n_m_last  = 1'b0;
                    n_m_empty = 1'b0;
                    n_state   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_skip) begin
                    n_left = r_left - LEFT_ONE;
                end else if (w_emit) begin
                    n_m_valid = 1'b1;
                    n_m_data  = digit_char(w_top);
                    n_m_last  = (r_left == LEFT_ONE);
                    n_m_empty = 1'b0;
                    n_started = 1'b1;
                    n_left    = r_left - LEFT_ONE;
                    if (r_left == LEFT_ONE) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_BAD: begin
                if (w_can_load) begin
                    n_m_valid = 1'b1;
                    n_m_data  = CHAR_NONE;
                    n_m_last  = 1'b1;
                    n_m_empty = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_radix   <= RADIX_RESET;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            if (i_cfg_wr_en) begin
                r_radix <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg     <= n_neg;
        r_left    <= n_left;
        r_started <= n_started;
        r_m_data  <= n_m_data;
        r_m_last  <= n_m_last;
        r_m_empty <= n_m_empty;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = r_m_empty;

`include "integer_to_radix_ascii_macros.svh"

    `IRA_ASSERT_NXT(a_busy_after_accept, w_s_acc, r_state != ST_IDLE, "idle after accept")
    `IRA_ASSERT_IMP(a_empty, r_m_valid && r_m_empty, r_m_last && (r_m_data == CHAR_NONE), "bad empty")
    `IRA_ASSERT_NXT(a_last_ends, w_emit && (r_left == LEFT_ONE), r_state == ST_IDLE, "not closed")
    `IRA_ASSERT_IMP(a_no_shift_in_conv, r_state == ST_CONV, !w_ctrl.shift, "shift in conv")
    `IRA_ASSERT_IMP(a_start_only_valid, w_ctrl.start, w_radix_ok, "start on bad radix")

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// integer_to_radix_ascii testbench
// Sends signed integers through the converter across a range of radix
// settings, valid and invalid, and checks every character, end marker and
// empty flag against a local prediction of the expected text. Both stream
// sides idle at random, and the output side is held off once for a long
// stretch so that the input has to stall.
// -----------------------------------------------------------------------------
module tb;
    import ira_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 110;
    localparam int PHASE_ITEMS  = 28;
    localparam int PHASE_COUNT  = 15;

    typedef struct packed {
        t_char code;
        logic  is_last;
        logic  is_empty;
    } t_text_char;

    localparam logic [31:0] DIR_DEC[7] = '{32'd0, 32'd1, 32'hffff_ffff, 32'h7fff_ffff,
                                            32'h8000_0000, 32'hffff_fff6, 32'd9};
    localparam logic [31:0] DIR_BIN[5] = '{32'd0, 32'h8000_0000, 32'hffff_ffff,
                                            32'h7fff_ffff, 32'h5555_5555};
    localparam logic [31:0] DIR_B36[5] = '{32'd35, 32'd36, 32'h8000_0000,
                                            32'h7fff_ffff, 32'hffff_ffdd};
    localparam t_radix PHASE_RADIX[9] = '{6'd2, 6'd36, 6'd16, 6'd8, 6'd3,
                                           6'd0, 6'd1, 6'd37, 6'd63};

    // expected text of every accepted number, one entry per character
    class radix_text_board;
        t_radix     radix_q;
        t_text_char expected_text[$];
        int         fault_count;

        function new();
            radix_q     = RADIX_RESET;
            fault_count = 0;
        endfunction

        function void take_number(logic [31:0] number);
            logic [31:0] mag;
            logic [31:0] base;
            logic [31:0] rem;
            t_char       ch;
            t_char       digit_text[$];
            t_text_char  c;
            if (radix_q < RADIX_MIN || radix_q > RADIX_MAX) begin
                c.code     = CHAR_NONE;
                c.is_last  = 1'b1;
                c.is_empty = 1'b1;
                expected_text.push_back(c);
                return;
            end
            base = 32'(radix_q);
            // unsigned negate also gives the right magnitude for the most negative value
            mag  = number[31] ? (~number + 32'd1) : number;
            do begin
                rem = mag % base;
                if (rem < 32'd10) begin
                    ch = CHAR_ZERO + t_char'(rem);
                end else begin
                    ch = CHAR_A + t_char'(rem - 32'd10);
                end
                digit_text.push_front(ch);
                mag = mag / base;
            end while (mag != 0);
            c.is_last  = 1'b0;
            c.is_empty = 1'b0;
            if (number[31] && radix_q == SIGNED_RADIX) begin
                c.code = CHAR_MINUS;
                expected_text.push_back(c);
            end
            foreach (digit_text[k]) begin
                c.code    = digit_text[k];
                c.is_last = (k == digit_text.size() - 1);
                expected_text.push_back(c);
            end
        endfunction

        function void check_char(t_char code, logic is_last, logic is_empty);
            t_text_char want;
            if (expected_text.size() == 0) begin
                $error("char_code %h arrived with no text expected", code);
                fault_count++;
                return;
            end
            want = expected_text.pop_front();
            if (code !== want.code) begin
                $error("char_code: expected %h, got %h", want.code, code);
                fault_count++;
            end
            if (is_last !== want.is_last) begin
                $error("last_char: expected %b, got %b", want.is_last, is_last);
                fault_count++;
            end
            if (is_empty !== want.is_empty) begin
                $error("empty_text: expected %b, got %b", want.is_empty, is_empty);
                fault_count++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    t_radix      i_cfg_wr_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;     // number_in
    logic        o_m_tvalid;
    logic        i_m_tready;
    t_char       o_m_tdata;     // char_code
    logic        o_m_tlast;     // last_char
    logic        o_m_tuser;     // empty_text

    radix_text_board board;
    bit              idle_on      = 1'b1;
    bit              hold_out_req = 1'b0;

    integer_to_radix_ascii dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast),
        .o_m_tuser     (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("integer_to_radix_ascii: mismatch");
        $finish;
    end

    function automatic logic [31:0] pick_number();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 40);
            2: return -$urandom_range(1, 40);
            3: return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 2)
                                           : 32'h7fff_ffff - $urandom_range(0, 2);
            4: return $unsigned($signed($urandom()) >>> $urandom_range(0, 31));
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic t_radix pick_radix();
        if ($urandom_range(0, 3) != 0) begin
            return t_radix'($urandom_range(2, 36));
        end else if ($urandom_range(0, 1) == 0) begin
            return t_radix'($urandom_range(0, 1));
        end else begin
            return t_radix'($urandom_range(37, 63));
        end
    endfunction

    task automatic push_number(input logic [31:0] number);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= number;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.take_number(number);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // only written once the converter has drained
    task automatic set_radix(input t_radix r);
        i_s_tvalid <= 1'b0;
        while (board.expected_text.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= r;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        board.radix_q = r;
    endtask

    // output side: checks each item and stalls in bursts or one long hold
    initial begin : text_sink
        int stall_left;
        stall_left = 0;
        i_m_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                board.check_char(o_m_tdata, o_m_tlast, o_m_tuser);
            end
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) begin
                    i_m_tready <= 1'b1;
                end
            end else if (hold_out_req) begin
                hold_out_req = 1'b0;
                stall_left   = HOLD_CYCLES;
                i_m_tready  <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left  = $urandom_range(1, 4);
                i_m_tready <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        t_radix r;
        board = new();
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= RADIX_RESET;
        i_s_tvalid    <= 1'b0;
        i_s_tdata     <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: radix from reset, then binary, base 36 and two bad radices
        foreach (DIR_DEC[k]) push_number(DIR_DEC[k]);
        set_radix(6'd2);
        foreach (DIR_BIN[k]) push_number(DIR_BIN[k]);
        set_radix(RADIX_MAX);
        foreach (DIR_B36[k]) push_number(DIR_B36[k]);
        set_radix(6'd0);
        push_number(32'd5);
        push_number(32'h8000_0000);
        set_radix(6'd63);
        push_number(32'hffff_ffff);
        push_number(32'd0);

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph < 9) begin
                r = PHASE_RADIX[ph];
            end else if (ph == PHASE_COUNT - 1) begin
                r = SIGNED_RADIX;
            end else begin
                r = pick_radix();
            end
            set_radix(r);
            if (ph == 3) begin
                hold_out_req = 1'b1;
            end
            if (ph == PHASE_COUNT - 1) begin
                idle_on = 1'b0;
            end
            repeat (PHASE_ITEMS) push_number(pick_number());
        end

        i_s_tvalid <= 1'b0;
        while (board.expected_text.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.fault_count == 0) begin
            $display("integer_to_radix_ascii: match");
        end else begin
            $display("integer_to_radix_ascii: mismatch");
        end
        $finish;
    end

endmodule
